// ----- hw/rtl/cmeai_pkg.sv -----
// Shared types, codes and helper functions for the cartridge mapper unit.
// Used by the controller, the datapath and the top level; no dependencies.
package cmeai_pkg;

  // Default depth of one attribute bank (entries of two bits).
  localparam int ATTR_BANK_DEPTH_DEF = 1024;

  // Bus event codes carried in the action field.
  localparam logic [2:0] ACT_REG_WRITE  = 3'd0;
  localparam logic [2:0] ACT_ATTR_WRITE = 3'd1;
  localparam logic [2:0] ACT_ID_READ    = 3'd2;
  localparam logic [2:0] ACT_CPU_TICK   = 3'd3;
  localparam logic [2:0] ACT_PPU_SAMPLE = 3'd4;
  localparam logic [2:0] ACT_PPU_READ   = 3'd5;

  // Register numbers taken from the low four address bits.
  localparam logic [3:0] REG_IRQ_LATCH  = 4'h8;
  localparam logic [3:0] REG_IRQ_RELOAD = 4'h9;
  localparam logic [3:0] REG_CONTROL    = 4'hA;
  localparam logic [3:0] REG_PRG        = 4'hB;
  localparam logic [3:0] REG_CHR_0      = 4'hC;
  localparam logic [3:0] REG_CHR_1      = 4'hD;
  localparam logic [3:0] REG_CHR_2      = 4'hE;
  localparam logic [3:0] REG_CHR_3      = 4'hF;

  // Mirroring modes.
  localparam logic [1:0] MIR_VERTICAL    = 2'd0;
  localparam logic [1:0] MIR_HORIZONTAL  = 2'd1;
  localparam logic [1:0] MIR_SINGLE_LOW  = 2'd2;
  localparam logic [1:0] MIR_SINGLE_HIGH = 2'd3;

  // Address constants.
  localparam logic [11:0] ATTR_WRITE_LIMIT = 12'h800;
  localparam logic [11:0] ID_AREA_START    = 12'h800;
  localparam logic [13:0] NT_AREA_START    = 14'h2000;
  localparam logic [13:0] NT_AREA_END      = 14'h3EFF;
  localparam logic [9:0]  ATTR_AREA_START  = 10'h3C0;
  localparam logic [7:0]  ID_BYTE          = 8'h64;

  typedef struct packed {
    logic [2:0]  action;
    logic [13:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_handled;
    logic       irq_line;
    logic [3:0] prg_bank;
    logic [3:0] chr_bank_a;
    logic [3:0] chr_bank_b;
    logic [3:0] chr_bank_c;
    logic [3:0] chr_bank_d;
    logic [1:0] mirroring;
    logic       sram_enable;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_sts_t;

  // Attribute bank chosen by the mirroring mode and the nametable number.
  function automatic logic nt_bank(input logic [1:0] mode, input logic [1:0] nt);
    logic b;
    unique case (mode)
      MIR_VERTICAL:   b = nt[0];
      MIR_HORIZONTAL: b = nt[1];
      MIR_SINGLE_LOW: b = 1'b0;
      default:        b = 1'b1;
    endcase
    return b;
  endfunction

  // Replicates a two-bit attribute into all four fields of a byte.
  function automatic logic [7:0] attr_fill(input logic [1:0] v);
    return {4{v}};
  endfunction

endpackage

// ----- hw/rtl/cmeai_ctrl.sv -----
// Controller state machine for the cartridge mapper unit.
// Depends on cmeai_pkg for the command and status structs.
module cmeai_ctrl import cmeai_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FORM
  } state_t;

  state_t state_r;

  // Inputs are taken only when idle.
  assign in_stall  = (state_r != ST_IDLE);
  assign cmd.clear = (state_r == ST_CLEAR);
  assign cmd.load  = (state_r == ST_IDLE) && in_valid;
  assign cmd.exec  = (state_r == ST_EXEC);
  assign cmd.emit  = (state_r == ST_FORM) && sts.out_free;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          if (sts.clear_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_r <= ST_FORM;
        end
        ST_FORM: begin
          if (sts.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/cmeai_dp.sv -----
// Datapath of the cartridge mapper unit: mapper registers, IRQ counter,
// PPU address history, attribute memory and the output register. Uses cmeai_pkg.
module cmeai_dp import cmeai_pkg::*; #(
  parameter int ATTR_BANK_DEPTH = ATTR_BANK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int ENTRIES = 2 * ATTR_BANK_DEPTH;
  localparam int IDX_W   = $clog2(ATTR_BANK_DEPTH);
  localparam int AW      = $clog2(ENTRIES);

  in_item_t     item_r;
  logic [3:0]   control_r;
  logic [3:0]   prg_r;
  logic [3:0]   chr_r [4];
  logic [7:0]   latch_low_r;
  logic [15:0]  count_r;
  logic [15:0]  count_nxt;
  logic         armed_r;
  logic         pending_r;
  logic [13:0]  addr_now_r;
  logic [13:0]  addr_before_r;
  logic         id_hit_r;
  logic         attr_hit_r;
  logic [AW-1:0] clr_cnt_r;
  logic [1:0]   attr_mem [ENTRIES];
  logic [1:0]   mem_rd_r;
  logic         out_valid_r;
  out_item_t    out_r;

  logic [11:0]  cpu_addr;
  logic         attr_wr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic         ppu_attr_cond;
  logic [7:0]   read_byte;

  assign cpu_addr  = item_r.address[11:0];
  assign count_nxt = count_r - 16'd1;

  // An attribute read inside the nametable area with override enabled.
  assign ppu_attr_cond = control_r[2]
                      && (item_r.address >= NT_AREA_START)
                      && (item_r.address <= NT_AREA_END)
                      && (item_r.address[9:0] >= ATTR_AREA_START);

  // Memory addresses: bank bit on top of the entry index.
  assign attr_wr = cmd.exec && (item_r.action == ACT_ATTR_WRITE)
                && (cpu_addr < ATTR_WRITE_LIMIT);
  assign wr_addr = {cpu_addr[10], cpu_addr[IDX_W-1:0]};
  assign rd_addr = {nt_bank(control_r[1:0], item_r.address[11:10]),
                    addr_before_r[IDX_W-1:0]};

  assign sts.clear_last = &clr_cnt_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Attribute memory: one write port shared by the clearing sweep, one read port.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      attr_mem[clr_cnt_r] <= 2'd0;
    end else if (attr_wr) begin
      attr_mem[wr_addr] <= item_r.data[1:0];
    end
    mem_rd_r <= attr_mem[rd_addr];
  end

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Accepted transaction is held for the whole of its processing.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  // Mapper state update and read decode, applied once per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r     <= '0;
      prg_r         <= '0;
      for (int i = 0; i < 4; i++) begin
        chr_r[i] <= 4'(i);
      end
      latch_low_r   <= '0;
      count_r       <= '0;
      armed_r       <= 1'b0;
      pending_r     <= 1'b0;
      addr_now_r    <= '0;
      addr_before_r <= '0;
      id_hit_r      <= 1'b0;
      attr_hit_r    <= 1'b0;
    end else if (cmd.exec) begin
      id_hit_r   <= (item_r.action == ACT_ID_READ) && (cpu_addr >= ID_AREA_START);
      attr_hit_r <= (item_r.action == ACT_PPU_READ) && ppu_attr_cond;
      unique case (item_r.action)
        ACT_REG_WRITE: begin
          unique case (item_r.address[3:0])
            REG_IRQ_LATCH: begin
              latch_low_r <= item_r.data;
            end
            REG_IRQ_RELOAD: begin
              count_r   <= {1'b0, item_r.data[6:0], latch_low_r};
              armed_r   <= item_r.data[7];
              pending_r <= 1'b0;
            end
            REG_CONTROL: begin
              control_r <= item_r.data[3:0];
            end
            REG_PRG: begin
              prg_r <= item_r.data[3:0];
            end
            REG_CHR_0, REG_CHR_1, REG_CHR_2, REG_CHR_3: begin
              chr_r[item_r.address[1:0]] <= item_r.data[3:0];
            end
            default: begin
            end
          endcase
        end
        ACT_CPU_TICK: begin
          if (armed_r) begin
            count_r <= count_nxt;
            if (count_nxt == 16'd0) begin
              pending_r <= 1'b1;
            end
          end
        end
        ACT_PPU_SAMPLE: begin
          addr_before_r <= addr_now_r;
          addr_now_r    <= item_r.address;
        end
        default: begin
        end
      endcase
    end
  end

  // Read byte: attribute override first, then the ID byte, else zero.
  always_comb begin
    priority if (attr_hit_r) begin
      read_byte = attr_fill(mem_rd_r);
    end else if (id_hit_r) begin
      read_byte = ID_BYTE;
    end else begin
      read_byte = 8'd0;
    end
  end

  // Output register; it frees as soon as the receiver takes its transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.read_data    <= read_byte;
      out_r.read_handled <= attr_hit_r || id_hit_r;
      out_r.irq_line     <= pending_r;
      out_r.prg_bank     <= prg_r;
      out_r.chr_bank_a   <= chr_r[0];
      out_r.chr_bank_b   <= chr_r[1];
      out_r.chr_bank_c   <= chr_r[2];
      out_r.chr_bank_d   <= chr_r[3];
      out_r.mirroring    <= control_r[1:0];
      out_r.sram_enable  <= control_r[3];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  // The two read sources never claim the same transaction.
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(attr_hit_r && id_hit_r))
    else $error("attribute and ID read both hit");

  // The IRQ pending flag only drops on a reload register write.
  a_pending_fall: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(pending_r)) |->
      ($past(cmd.exec) && $past(item_r.action) == ACT_REG_WRITE
       && $past(item_r.address[3:0]) == REG_IRQ_RELOAD))
    else $error("IRQ pending cleared without reload write");

  // No result is presented while the memory is still being cleared.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (!out_valid_r && !cmd.load && !cmd.exec))
    else $error("activity during clearing sweep");

  // A new result is loaded only when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten");
`endif

endmodule

// ----- hw/rtl/cartridge_mapper_ext_attr_irq_unit.sv -----
// Top level of the cartridge mapper unit with attribute RAM and CPU-cycle IRQ.
// Joins cmeai_ctrl and cmeai_dp; types come from cmeai_pkg.
//
// Usage:
//   The input channel (in_valid, in_stall, in_item) carries one bus event per
//   transaction: register write, attribute RAM write, ID read, CPU tick, PPU
//   address sample or PPU read. The result channel (out_valid, out_stall,
//   out_item) returns exactly one transaction per input: read data with its
//   handled flag, the IRQ level, bank numbers, mirroring and SRAM enable.
//   Each event passes through accept, execute (state update and attribute RAM
//   read on its registered port), then loading of the output register, which
//   raises out_valid; loading waits while the output register is still held.
//   After reset the unit sweeps the attribute RAM (2048 entries by default) to
//   zero, one entry per cycle, holding in_stall high until the sweep ends.
//   When the receiver stalls, the result holds in the output register; the
//   next event may be accepted and executed meanwhile, but its result waits
//   until the output register is taken.
module cartridge_mapper_ext_attr_irq_unit import cmeai_pkg::*; #(
  parameter int ATTR_BANK_DEPTH = ATTR_BANK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing.
  cmeai_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Registers, memory and result forming.
  cmeai_dp #(
    .ATTR_BANK_DEPTH (ATTR_BANK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
